FILE: src/msrs_pkg.sv
// Package for the Morton range split search block.
// Holds field widths, operation codes, the sequencer state type and the prefix mask function.
// No dependencies.
package msrs_pkg;

   localparam int IDX_W  = 10;
   localparam int CODE_W = 32;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_HI,
      ST_ENDS,
      ST_EVAL,
      ST_FINAL,
      ST_OUT
   } srch_state_type;

   // Marks every bit from the highest set bit of diff up to the top.
   // A code shares a strictly longer prefix with the first code exactly when
   // its difference from the first code has no bit set under this mask.
   function automatic logic [CODE_W-1:0] prefix_mask(input logic [CODE_W-1:0] diff);
      logic [CODE_W-1:0] v;
      v = diff;
      v = v | (v >> 1);
      v = v | (v >> 2);
      v = v | (v >> 4);
      v = v | (v >> 8);
      v = v | (v >> 16);
      return ~(v >> 1);
   endfunction

endpackage

FILE: src/morton_range_split_search.sv
// Top level of the Morton range split search block: beat handshakes and the search sequencer.
// Depends on msrs_pkg and msrs_store.
//
//   channel | direction | tdata (lowest bit up)                          | tuser
//   req     | in        | load_index, load_code, range_low, range_high   | operation
//   rsp     | out       | split_index                                    | range_error
//
// A load beat writes its code into the store. A query reads the two range ends and
// compares them; if they match, the midpoint of the range is the answer. Otherwise it
// runs binary search steps through the single store read port (about log2 of the range
// length of them), then a final check, and hands off the result.
// An inverted range skips the search and returns range_error. Reset is synchronous and
// clears only the sequencer and the output valid; the store has no clearing pass.
module morton_range_split_search #(
   parameter int DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // load_index, load_code, range_low, range_high, zero fill
   input  logic        req_tuser,  // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // split_index, zero fill
   output logic        rsp_tuser   // range_error
);
   import msrs_pkg::*;

   srch_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic [IDX_W-1:0]  left_ff, left_in;
   logic [IDX_W-1:0]  right_ff, right_in;
   logic [IDX_W-1:0]  mid_ff, mid_in;
   logic [CODE_W-1:0] first_ff, first_in;
   logic [CODE_W-1:0] mask_ff, mask_in;
   logic [IDX_W-1:0]  pend_index_ff, pend_index_in;
   logic              pend_error_ff, pend_error_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic              rsp_error_ff, rsp_error_in;

   logic [IDX_W-1:0]  req_load_index;
   logic [CODE_W-1:0] req_load_code;
   logic [IDX_W-1:0]  req_range_low;
   logic [IDX_W-1:0]  req_range_high;
   logic              req_accept;
   logic              wr_en;
   logic [IDX_W-1:0]  rd_index;
   logic [CODE_W-1:0] rd_code;
   logic              hit;
   logic [IDX_W-1:0]  seed_left;
   logic [IDX_W-1:0]  seed_right;
   logic [IDX_W:0]    seed_sum;
   logic [IDX_W-1:0]  mid_next;
   logic              more;

   assign req_load_index = req_tdata[9:0];
   assign req_load_code  = req_tdata[41:10];
   assign req_range_low  = req_tdata[51:42];
   assign req_range_high = req_tdata[61:52];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign wr_en      = req_accept && (req_tuser == OP_LOAD);

   msrs_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_index (req_load_index),
      .wr_code  (req_load_code),
      .rd_index (rd_index),
      .rd_code  (rd_code)
   );

   // Shared compare unit and next search interval.
   assign hit        = ((first_ff ^ rd_code) & mask_ff) == '0;
   assign seed_left  = (state_ff == ST_ENDS) ? lo_ff : (hit ? mid_ff : left_ff);
   assign seed_right = (state_ff == ST_ENDS) ? hi_ff : (hit ? right_ff : mid_ff);
   assign seed_sum   = {1'b0, seed_left} + {1'b0, seed_right};
   assign mid_next   = seed_sum[IDX_W:1];
   assign more       = ({1'b0, seed_left} + (IDX_W+1)'(1)) < {1'b0, seed_right};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      left_ff       <= left_in;
      right_ff      <= right_in;
      mid_ff        <= mid_in;
      first_ff      <= first_in;
      mask_ff       <= mask_in;
      pend_index_ff <= pend_index_in;
      pend_error_ff <= pend_error_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_error_ff  <= rsp_error_in;
   end

   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      mid_in        = mid_ff;
      first_in      = first_ff;
      mask_in       = mask_ff;
      pend_index_in = pend_index_ff;
      pend_error_in = pend_error_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_index_in  = rsp_index_ff;
      rsp_error_in  = rsp_error_ff;
      rd_index      = req_range_low;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == OP_QUERY)) begin
               if (req_range_low > req_range_high) begin
                  pend_index_in = '0;
                  pend_error_in = 1'b1;
                  state_in      = ST_OUT;
               end else begin
                  lo_in    = req_range_low;
                  hi_in    = req_range_high;
                  state_in = ST_READ_HI;
               end
            end
         end
         ST_READ_HI: begin
            rd_index = hi_ff;
            first_in = rd_code;
            state_in = ST_ENDS;
         end
         ST_ENDS: begin
            if (first_ff == rd_code) begin
               pend_index_in = mid_next;
               pend_error_in = 1'b0;
               state_in      = ST_OUT;
            end else begin
               mask_in  = prefix_mask(first_ff ^ rd_code);
               left_in  = seed_left;
               right_in = seed_right;
               mid_in   = mid_next;
               rd_index = more ? mid_next : seed_left;
               state_in = more ? ST_EVAL : ST_FINAL;
            end
         end
         ST_EVAL: begin
            left_in  = seed_left;
            right_in = seed_right;
            mid_in   = mid_next;
            rd_index = more ? mid_next : seed_left;
            state_in = more ? ST_EVAL : ST_FINAL;
         end
         ST_FINAL: begin
            pend_index_in = hit ? left_ff : right_ff;
            pend_error_in = 1'b0;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = pend_index_ff;
               rsp_error_in = pend_error_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 16'(rsp_index_ff);
   assign rsp_tuser  = rsp_error_ff;

endmodule

FILE: src/msrs_store.sv
// Code store of the Morton range split search block: one write and one registered read port.
// Indexes at or beyond DEPTH are dropped on write and read back as zero.
// Depends on msrs_pkg.
module msrs_store #(
   parameter int DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [msrs_pkg::IDX_W-1:0]    wr_index,
   input  logic [msrs_pkg::CODE_W-1:0]   wr_code,
   input  logic [msrs_pkg::IDX_W-1:0]    rd_index,
   output logic [msrs_pkg::CODE_W-1:0]   rd_code
);
   import msrs_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int XW = ((AW > IDX_W) ? AW : IDX_W) + 1;

   logic [CODE_W-1:0] mem_ff [DEPTH];
   logic [CODE_W-1:0] rd_data_ff;
   logic              rd_hit_ff;
   logic [XW-1:0]     wr_ext;
   logic [XW-1:0]     rd_ext;
   logic              wr_ok;
   logic              rd_ok;

   assign wr_ext = XW'(wr_index);
   assign rd_ext = XW'(rd_index);
   assign wr_ok  = wr_ext < XW'(DEPTH);
   assign rd_ok  = rd_ext < XW'(DEPTH);

   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem_ff[wr_ext[AW-1:0]] <= wr_code;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_ext[AW-1:0]];
      rd_hit_ff  <= rd_ok;
   end

   assign rd_code = rd_hit_ff ? rd_data_ff : '0;

endmodule
